// ----- src/v3au_pkg.sv -----
// Package for the three-component vector arithmetic unit.
// Holds operation codes, format constants and shared types; depends on nothing.
package v3au_pkg;

    localparam int FracBits = 16;
    localparam int WordBits = 32;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_SCALE = 3'd2;
    localparam logic [2:0] OP_DOT   = 3'd3;
    localparam logic [2:0] OP_CROSS = 3'd4;
    localparam logic [2:0] OP_LEN   = 3'd5;
    localparam logic [2:0] OP_NORM  = 3'd6;

    // Pipeline control that travels beside the data.
    typedef struct packed {
        logic       vld;
        logic [2:0] kind;
        logic       zero;
    } t_ctl;

endpackage

// ----- src/v3au_root.sv -----
// Pipelined square root, one result bit per stage, round to nearest.
// Depends on nothing outside this file; used by the top level.
module v3au_root #(
    parameter int IN_BITS  = 128,
    parameter int OUT_BITS = 64
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [IN_BITS-1:0]  i_val,
    output logic [OUT_BITS:0]   o_root
);

    logic [IN_BITS-1:0]  r_val [OUT_BITS+1];
    logic [OUT_BITS-1:0] r_rt  [OUT_BITS+1];

    always_comb begin
        r_val[0] = i_val;
        r_rt[0]  = '0;
    end

    // Each stage tries one bit, from the top down, and keeps the remainder.
    for (genvar g = 0; g < OUT_BITS; g++) begin : g_stage
        localparam int B = OUT_BITS - 1 - g;
        logic [IN_BITS-1:0]  n_sq;
        logic [OUT_BITS-1:0] n_c;
        logic [IN_BITS-1:0]  r_v;
        logic [OUT_BITS-1:0] r_r;
        always_comb begin
            n_c  = r_rt[g] | (OUT_BITS'(1) << B);
            n_sq = (IN_BITS'(r_rt[g]) << (B + 1)) + (IN_BITS'(1) << (2 * B));
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (n_sq <= r_val[g]) begin
                    r_v <= r_val[g] - n_sq;
                    r_r <= n_c;
                end else begin
                    r_v <= r_val[g];
                    r_r <= r_rt[g];
                end
            end
        end
        always_comb begin
            r_val[g+1] = r_v;
            r_rt[g+1]  = r_r;
        end
    end

    assign o_root = (r_val[OUT_BITS] > IN_BITS'(r_rt[OUT_BITS]))
                  ? {1'b0, r_rt[OUT_BITS]} + (OUT_BITS + 1)'(1)
                  : {1'b0, r_rt[OUT_BITS]};

endmodule

// ----- src/v3au_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing outside this file; one copy per lane of the top level.
module v3au_div #(
    parameter int N_BITS = 64,
    parameter int D_BITS = 33,
    parameter int Q_BITS = 33
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [N_BITS-1:0]  i_num,
    input  logic [D_BITS-1:0]  i_den,
    output logic [Q_BITS-1:0]  o_quo
);

    logic [N_BITS-1:0] s_n [Q_BITS+1];
    logic [D_BITS:0]   s_r [Q_BITS+1];
    logic [D_BITS-1:0] s_d [Q_BITS+1];
    logic [Q_BITS-1:0] s_q [Q_BITS+1];

    // The top bits of the numerator lie below the divisor by construction.
    always_comb begin
        s_n[0] = i_num;
        s_r[0] = (D_BITS + 1)'(i_num >> Q_BITS);
        s_d[0] = i_den;
        s_q[0] = '0;
    end

    for (genvar g = 0; g < Q_BITS; g++) begin : g_stage
        localparam int I = Q_BITS - 1 - g;
        logic [D_BITS:0]   n_t;
        logic [N_BITS-1:0] r_n;
        logic [D_BITS:0]   r_r;
        logic [D_BITS-1:0] r_d;
        logic [Q_BITS-1:0] r_q;
        assign n_t = {s_r[g][D_BITS-1:0], s_n[g][I]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n <= s_n[g];
                r_d <= s_d[g];
                if (n_t >= {1'b0, s_d[g]}) begin
                    r_r <= n_t - {1'b0, s_d[g]};
                    r_q <= s_q[g] | (Q_BITS'(1) << I);
                end else begin
                    r_r <= n_t;
                    r_q <= s_q[g];
                end
            end
        end
        always_comb begin
            s_n[g+1] = r_n;
            s_r[g+1] = r_r;
            s_d[g+1] = r_d;
            s_q[g+1] = r_q;
        end
    end

    assign o_quo = s_q[Q_BITS];

endmodule

// ----- src/vector3_arithmetic_unit.sv -----
// Three-component vector ALU: add, sub, scale, dot, cross, length, normalize.
// Its depth is set by the bit-per-stage square root and the bit-per-stage lane dividers.
// Throughput is one word per cycle; the whole pipeline advances when the output
// register is empty or being taken. Reset (i_rst_n low, synchronous) clears valids.
// Uses v3au_pkg, v3au_root and v3au_div.
module vector3_arithmetic_unit #(
    parameter int FRAC_BITS = v3au_pkg::FracBits,
    parameter int WORD_BITS = v3au_pkg::WordBits
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [2:0]                  i_kind,
    input  logic signed [WORD_BITS-1:0] i_ux,
    input  logic signed [WORD_BITS-1:0] i_uy,
    input  logic signed [WORD_BITS-1:0] i_uz,
    input  logic signed [WORD_BITS-1:0] i_vx,
    input  logic signed [WORD_BITS-1:0] i_vy,
    input  logic signed [WORD_BITS-1:0] i_vz,
    input  logic signed [WORD_BITS-1:0] i_factor,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [WORD_BITS-1:0] o_rx,
    output logic signed [WORD_BITS-1:0] o_ry,
    output logic signed [WORD_BITS-1:0] o_rz,
    output logic signed [WORD_BITS-1:0] o_scalar,
    output logic                        o_overflow,
    output logic                        o_zero_vector
);

    localparam int W   = WORD_BITS;
    localparam int PW  = 2 * W;        // product width
    localparam int SW  = 2 * W + 2;    // sum of three products
    localparam int RB  = W + 1;        // root bits (magnitude fits W+1)
    localparam int RT  = 2 * RB;       // root input width
    localparam int QB  = W + 1;        // quotient bits kept
    localparam int NB  = W + 1 + FRAC_BITS + 1; // divider numerator
    localparam int DDEP = QB;          // divider depth
    localparam int SH_BITS = $clog2(W);
    localparam logic signed [SW-1:0] MAXW = SW'((64'd1 << (W - 1)) - 64'd1);
    localparam logic signed [SW-1:0] MINW = -MAXW - SW'(1);

    // The pipeline moves as a whole; the output register frees as it is read.
    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // Saturate a wide signed value to the word, flagging overflow.
    function automatic logic [W:0] f_sat(input logic signed [SW-1:0] a);
        if (a > MAXW)      f_sat = {1'b1, MAXW[W-1:0]};
        else if (a < MINW) f_sat = {1'b1, MINW[W-1:0]};
        else               f_sat = {1'b0, a[W-1:0]};
    endfunction

    // Round to nearest, ties up, drop the fraction, then saturate.
    function automatic logic [W:0] f_rnd(input logic signed [SW-1:0] a);
        logic signed [SW-1:0] t;
        t = (a + (SW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        f_rnd = f_sat(t);
    endfunction

    // ---------------- stage 1: lanes form products ----------------
    v3au_pkg::t_ctl r1_c;
    logic signed [W-1:0]  r1_u [3];
    logic signed [W-1:0]  r1_v [3];
    logic signed [PW-1:0] r1_p [3];  // lane product (scale, dot, square)
    logic signed [PW-1:0] r1_a [3];  // cross first term
    logic signed [PW-1:0] r1_b [3];  // cross second term

    logic signed [W-1:0] n_u [3];
    logic signed [W-1:0] n_v [3];
    logic [W-1:0]        n_m [3];
    logic [W-1:0]        n_mx;
    logic [SH_BITS:0]    n_sh;
    logic signed [W-1:0] n_nu [3];

    always_comb begin
        n_u[0] = i_ux; n_u[1] = i_uy; n_u[2] = i_uz;
        n_v[0] = i_vx; n_v[1] = i_vy; n_v[2] = i_vz;
        for (int k = 0; k < 3; k++) begin
            n_m[k] = n_u[k][W-1] ? W'(-n_u[k]) : W'(n_u[k]);
        end
        n_mx = n_m[0];
        if (n_m[1] > n_mx) n_mx = n_m[1];
        if (n_m[2] > n_mx) n_mx = n_m[2];
        // Shift that brings the largest magnitude up to bit W-2.
        n_sh = '0;
        for (int b = 0; b < W - 1; b++) begin
            if (n_mx[b]) n_sh = (SH_BITS + 1)'(W - 2 - b);
        end
        if (n_mx[W-1]) n_sh = '0;
        for (int k = 0; k < 3; k++) begin
            n_nu[k] = (i_kind == v3au_pkg::OP_NORM) ? (n_u[k] <<< n_sh) : n_u[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_c.vld <= 1'b0;
        end else if (en) begin
            r1_c.vld <= i_valid;
        end
        if (en) begin
            r1_c.kind <= i_kind;
            r1_c.zero <= (n_mx == '0);
            for (int k = 0; k < 3; k++) begin
                r1_u[k] <= n_nu[k];
                r1_v[k] <= n_v[k];
                case (i_kind)
                    v3au_pkg::OP_SCALE: r1_p[k] <= PW'(i_factor) * PW'(n_u[k]);
                    v3au_pkg::OP_DOT:   r1_p[k] <= PW'(n_u[k]) * PW'(n_v[k]);
                    default:            r1_p[k] <= PW'(n_nu[k]) * PW'(n_nu[k]);
                endcase
            end
            r1_a[0] <= PW'(i_uy) * PW'(i_vz);
            r1_b[0] <= PW'(i_uz) * PW'(i_vy);
            r1_a[1] <= PW'(i_uz) * PW'(i_vx);
            r1_b[1] <= PW'(i_ux) * PW'(i_vz);
            r1_a[2] <= PW'(i_ux) * PW'(i_vy);
            r1_b[2] <= PW'(i_uy) * PW'(i_vx);
        end
    end

    // ---------------- stage 2: merge lanes, round, saturate ----------------
    v3au_pkg::t_ctl r2_c;
    logic [W:0]          r2_r [3];   // {ovf, value}
    logic [W:0]          r2_s;
    logic [RT-1:0]       r2_sq;
    logic signed [W-1:0] r2_u [3];
    logic signed [SW-1:0] n_sum;
    logic [W:0]          n_r [3];
    logic [W:0]          n_s;

    assign n_sum = SW'(r1_p[0]) + SW'(r1_p[1]) + SW'(r1_p[2]);

    // Fast results; length, normalize and the spare code leave these at zero.
    always_comb begin
        n_s = '0;
        for (int k = 0; k < 3; k++) n_r[k] = '0;
        case (r1_c.kind)
            v3au_pkg::OP_ADD: begin
                for (int k = 0; k < 3; k++)
                    n_r[k] = f_sat(SW'(r1_u[k]) + SW'(r1_v[k]));
            end
            v3au_pkg::OP_SUB: begin
                for (int k = 0; k < 3; k++)
                    n_r[k] = f_sat(SW'(r1_u[k]) - SW'(r1_v[k]));
            end
            v3au_pkg::OP_SCALE: begin
                for (int k = 0; k < 3; k++) n_r[k] = f_rnd(SW'(r1_p[k]));
            end
            v3au_pkg::OP_DOT: n_s = f_rnd(n_sum);
            v3au_pkg::OP_CROSS: begin
                for (int k = 0; k < 3; k++)
                    n_r[k] = f_rnd(SW'(r1_a[k]) - SW'(r1_b[k]));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_c.vld <= 1'b0;
        end else if (en) begin
            r2_c.vld <= r1_c.vld;
        end
        if (en) begin
            r2_c.kind <= r1_c.kind;
            r2_c.zero <= r1_c.zero;
            r2_sq     <= RT'(n_sum);
            r2_s      <= n_s;
            for (int k = 0; k < 3; k++) begin
                r2_u[k] <= r1_u[k];
                r2_r[k] <= n_r[k];
            end
        end
    end

    // ---------------- square root pipeline ----------------
    logic [RB:0] root;
    v3au_root #(.IN_BITS(RT), .OUT_BITS(RB)) u_root (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (r2_sq),
        .o_root (root)
    );

    // Delay line that keeps the fast results beside the root.
    v3au_pkg::t_ctl      d_c [RB+1];
    logic [W:0]          d_r [RB+1][3];
    logic [W:0]          d_s [RB+1];
    logic signed [W-1:0] d_u [RB+1][3];

    always_comb begin
        d_c[0] = r2_c;
        d_s[0] = r2_s;
        for (int k = 0; k < 3; k++) begin
            d_r[0][k] = r2_r[k];
            d_u[0][k] = r2_u[k];
        end
    end

    for (genvar g = 0; g < RB; g++) begin : g_dly
        v3au_pkg::t_ctl      r_c;
        logic [W:0]          r_r [3];
        logic [W:0]          r_s;
        logic signed [W-1:0] r_u [3];
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c.vld <= 1'b0;
            end else if (en) begin
                r_c.vld <= d_c[g].vld;
            end
            if (en) begin
                r_c.kind <= d_c[g].kind;
                r_c.zero <= d_c[g].zero;
                r_s      <= d_s[g];
                for (int k = 0; k < 3; k++) begin
                    r_r[k] <= d_r[g][k];
                    r_u[k] <= d_u[g][k];
                end
            end
        end
        always_comb begin
            d_c[g+1] = r_c;
            d_s[g+1] = r_s;
            for (int k = 0; k < 3; k++) begin
                d_r[g+1][k] = r_r[k];
                d_u[g+1][k] = r_u[k];
            end
        end
    end

    // ---------------- stage 3: length result and divider set-up ----------------
    v3au_pkg::t_ctl r3_c;
    logic [W:0]     r3_r [3];
    logic [W:0]     r3_s;
    logic           r3_neg [3];
    logic [NB-1:0]  r3_num [3];
    logic [RB-1:0]  r3_den;
    logic [W-1:0]   n_mg [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_mg[k] = d_u[RB][k][W-1] ? W'(-d_u[RB][k]) : W'(d_u[RB][k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_c.vld <= 1'b0;
        end else if (en) begin
            r3_c.vld <= d_c[RB].vld;
        end
        if (en) begin
            r3_c.kind <= d_c[RB].kind;
            r3_c.zero <= d_c[RB].zero;
            r3_den    <= (root[RB-1:0] == '0) ? RB'(1) : root[RB-1:0];
            for (int k = 0; k < 3; k++) begin
                r3_r[k]   <= d_r[RB][k];
                r3_neg[k] <= d_u[RB][k][W-1];
                r3_num[k] <= (NB'(n_mg[k]) << FRAC_BITS) + NB'(root[RB-1:1]);
            end
            if (d_c[RB].kind == v3au_pkg::OP_LEN) begin
                if (root > (RB + 1)'(MAXW[W-1:0]))
                    r3_s <= {1'b1, MAXW[W-1:0]};
                else
                    r3_s <= {1'b0, root[W-1:0]};
            end else begin
                r3_s <= d_s[RB];
            end
        end
    end

    // ---------------- divider lanes ----------------
    logic [QB-1:0] quo [3];
    for (genvar k = 0; k < 3; k++) begin : g_lane
        v3au_div #(.N_BITS(NB), .D_BITS(RB), .Q_BITS(QB)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r3_num[k]),
            .i_den (r3_den),
            .o_quo (quo[k])
        );
    end

    v3au_pkg::t_ctl e_c [DDEP+1];
    logic [W:0]     e_r [DDEP+1][3];
    logic [W:0]     e_s [DDEP+1];
    logic           e_n [DDEP+1][3];

    always_comb begin
        e_c[0] = r3_c;
        e_s[0] = r3_s;
        for (int k = 0; k < 3; k++) begin
            e_r[0][k] = r3_r[k];
            e_n[0][k] = r3_neg[k];
        end
    end

    for (genvar g = 0; g < DDEP; g++) begin : g_dly2
        v3au_pkg::t_ctl r_c;
        logic [W:0]     r_r [3];
        logic [W:0]     r_s;
        logic           r_n [3];
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c.vld <= 1'b0;
            end else if (en) begin
                r_c.vld <= e_c[g].vld;
            end
            if (en) begin
                r_c.kind <= e_c[g].kind;
                r_c.zero <= e_c[g].zero;
                r_s      <= e_s[g];
                for (int k = 0; k < 3; k++) begin
                    r_r[k] <= e_r[g][k];
                    r_n[k] <= e_n[g][k];
                end
            end
        end
        always_comb begin
            e_c[g+1] = r_c;
            e_s[g+1] = r_s;
            for (int k = 0; k < 3; k++) begin
                e_r[g+1][k] = r_r[k];
                e_n[g+1][k] = r_n[k];
            end
        end
    end

    // ---------------- output register: merge normalize lanes ----------------
    logic [W:0] n_q [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (quo[k] > QB'(MAXW[W-1:0]))
                n_q[k] = {1'b1, e_n[DDEP][k] ? W'(-MAXW[W-1:0]) : MAXW[W-1:0]};
            else
                n_q[k] = {1'b0, e_n[DDEP][k] ? W'(-quo[k][W-1:0]) : quo[k][W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= e_c[DDEP].vld;
        end
        if (en) begin
            o_scalar <= e_s[DDEP][W-1:0];
            if (e_c[DDEP].kind == v3au_pkg::OP_NORM) begin
                if (e_c[DDEP].zero) begin
                    o_rx <= '0; o_ry <= '0; o_rz <= '0;
                    o_overflow    <= 1'b0;
                    o_zero_vector <= 1'b1;
                end else begin
                    o_rx <= n_q[0][W-1:0];
                    o_ry <= n_q[1][W-1:0];
                    o_rz <= n_q[2][W-1:0];
                    o_overflow    <= n_q[0][W] | n_q[1][W] | n_q[2][W];
                    o_zero_vector <= 1'b0;
                end
            end else begin
                o_rx <= e_r[DDEP][0][W-1:0];
                o_ry <= e_r[DDEP][1][W-1:0];
                o_rz <= e_r[DDEP][2][W-1:0];
                o_overflow <= e_r[DDEP][0][W] | e_r[DDEP][1][W] | e_r[DDEP][2][W]
                            | e_s[DDEP][W];
                o_zero_vector <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    // A stalled result must not move or vanish.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rx) && $stable(o_scalar))
        else $error("result changed while stalled");
    // Zero-vector flag only accompanies an all-zero vector result.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_vector |-> o_rx == '0 && o_ry == '0 && o_rz == '0
        && !o_overflow)
        else $error("zero vector flag with non-zero result");
    // Ready is high whenever the output register is empty.
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");
`endif

endmodule

// ----- dv/vector3_arithmetic_unit_checker.sv -----
// Scoreboard for the three-component vector arithmetic unit.
// Watches both channels, predicts each result and compares it; depends on v3au_pkg.
module vector3_arithmetic_unit_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [2:0]         i_kind,
    input  logic signed [31:0] i_ux,
    input  logic signed [31:0] i_uy,
    input  logic signed [31:0] i_uz,
    input  logic signed [31:0] i_vx,
    input  logic signed [31:0] i_vy,
    input  logic signed [31:0] i_vz,
    input  logic signed [31:0] i_factor,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_rx,
    input  logic signed [31:0] i_ry,
    input  logic signed [31:0] i_rz,
    input  logic signed [31:0] i_scalar,
    input  logic               i_overflow,
    input  logic               i_zero_vector,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);

    typedef struct packed {
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] rz;
        logic [31:0] scalar;
        logic        overflow;
        logic        zero_vector;
    } t_vec_result;

    localparam logic signed [127:0] MaxWord = 128'sd2147483647;
    localparam logic signed [127:0] MinWord = -128'sd2147483648;

    t_vec_result awaited_results[$];

    function automatic logic signed [127:0] widen(input logic signed [31:0] x);
        return x;
    endfunction

    function automatic logic [31:0] clamp(input logic signed [127:0] v, inout logic ovf);
        if (v > MaxWord) begin
            ovf = 1'b1;
            return MaxWord[31:0];
        end
        if (v < MinWord) begin
            ovf = 1'b1;
            return MinWord[31:0];
        end
        return v[31:0];
    endfunction

    // Round to nearest with ties upwards, then drop the fraction bits.
    function automatic logic signed [127:0] round_q(input logic signed [127:0] v);
        return (v + (128'sd1 <<< (v3au_pkg::FracBits - 1))) >>> v3au_pkg::FracBits;
    endfunction

    function automatic logic [127:0] root_nearest(input logic [127:0] s);
        logic [127:0] r;
        logic [127:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= s) r = c;
        end
        if (s - r * r > r) r = r + 1;
        return r;
    endfunction

    function automatic t_vec_result vector_op_result(
        input logic [2:0] kind,
        input logic signed [31:0] u [3],
        input logic signed [31:0] v [3],
        input logic signed [31:0] f
    );
        t_vec_result res;
        logic ovf;
        logic [31:0] r [3];
        logic signed [127:0] p [3];
        logic [127:0] m, len, num, q;
        int shift;
        ovf = 1'b0;
        res = '0;
        for (int i = 0; i < 3; i++) r[i] = '0;
        case (kind)
            v3au_pkg::OP_ADD: for (int i = 0; i < 3; i++)
                r[i] = clamp(widen(u[i]) + widen(v[i]), ovf);
            v3au_pkg::OP_SUB: for (int i = 0; i < 3; i++)
                r[i] = clamp(widen(u[i]) - widen(v[i]), ovf);
            v3au_pkg::OP_SCALE: for (int i = 0; i < 3; i++)
                r[i] = clamp(round_q(widen(f) * widen(u[i])), ovf);
            v3au_pkg::OP_DOT: res.scalar = clamp(round_q(widen(u[0]) * widen(v[0])
                + widen(u[1]) * widen(v[1]) + widen(u[2]) * widen(v[2])), ovf);
            v3au_pkg::OP_CROSS: begin
                r[0] = clamp(round_q(widen(u[1]) * widen(v[2])
                    - widen(u[2]) * widen(v[1])), ovf);
                r[1] = clamp(round_q(widen(u[2]) * widen(v[0])
                    - widen(u[0]) * widen(v[2])), ovf);
                r[2] = clamp(round_q(widen(u[0]) * widen(v[1])
                    - widen(u[1]) * widen(v[0])), ovf);
            end
            v3au_pkg::OP_LEN: begin
                len = root_nearest(widen(u[0]) * widen(u[0]) + widen(u[1]) * widen(u[1])
                    + widen(u[2]) * widen(u[2]));
                res.scalar = clamp(len, ovf);
            end
            v3au_pkg::OP_NORM: begin
                m = 0;
                for (int i = 0; i < 3; i++) begin
                    p[i] = widen(u[i]) < 0 ? -widen(u[i]) : widen(u[i]);
                    if (p[i] > m) m = p[i];
                end
                if (m == 0) begin
                    res.zero_vector = 1'b1;
                end else begin
                    // Bring the largest component up to 2^30 before taking the length.
                    shift = 0;
                    while (m < (128'd1 << (v3au_pkg::WordBits - 2))) begin
                        m = m << 1;
                        shift++;
                    end
                    for (int i = 0; i < 3; i++) p[i] = widen(u[i]) <<< shift;
                    len = root_nearest(p[0] * p[0] + p[1] * p[1] + p[2] * p[2]);
                    for (int i = 0; i < 3; i++) begin
                        num = ((p[i] < 0 ? -p[i] : p[i]) << v3au_pkg::FracBits) + (len >> 1);
                        q = num / len;
                        if (q > MaxWord) begin
                            ovf = 1'b1;
                            q = MaxWord;
                        end
                        r[i] = p[i] < 0 ? -q[31:0] : q[31:0];
                    end
                end
            end
            default: ;
        endcase
        res.rx = r[0];
        res.ry = r[1];
        res.rz = r[2];
        res.overflow = ovf;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH result %0d field %s: got %h, expected %h",
                 o_checked, field, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_checked = 0;
    end

    assign o_pending = awaited_results.size();

    always @(posedge i_clk) begin
        logic signed [31:0] u [3];
        logic signed [31:0] v [3];
        t_vec_result want;
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                // A result word arrived with nothing outstanding.
                report_mismatch("valid", 32'd1, 32'd0);
            end else begin
                want = awaited_results.pop_front();
                if (i_rx !== want.rx) report_mismatch("rx", i_rx, want.rx);
                if (i_ry !== want.ry) report_mismatch("ry", i_ry, want.ry);
                if (i_rz !== want.rz) report_mismatch("rz", i_rz, want.rz);
                if (i_scalar !== want.scalar) report_mismatch("scalar", i_scalar, want.scalar);
                if (i_overflow !== want.overflow)
                    report_mismatch("overflow", i_overflow, want.overflow);
                if (i_zero_vector !== want.zero_vector)
                    report_mismatch("zero_vector", i_zero_vector, want.zero_vector);
            end
            o_checked++;
        end
        if (i_rst_n && i_in_valid && i_in_ready) begin
            u = '{i_ux, i_uy, i_uz};
            v = '{i_vx, i_vy, i_vz};
            awaited_results.push_back(vector_op_result(i_kind, u, v, i_factor));
        end
    end

endmodule

// ----- dv/vector3_arithmetic_unit_tb.sv -----
// Top of the testbench for the three-component vector arithmetic unit.
// Drives operand words and random back-pressure; depends on v3au_pkg, the unit and its checker.
module vector3_arithmetic_unit_tb;

    // The final drain waits longer than the pipeline is deep at the default width.
    localparam int DrainCycles = 200;
    localparam int LongHold    = 400;
    localparam logic [2:0] OP_SPARE = 3'd7;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [2:0]         i_kind;
    logic signed [31:0] i_ux, i_uy, i_uz, i_vx, i_vy, i_vz, i_factor;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_rx, o_ry, o_rz, o_scalar;
    logic               o_overflow;
    logic               o_zero_vector;

    int  fail_count;
    int  outstanding;
    int  checked;
    int  words_sent;
    bit  send_gaps;
    bit  sink_stalls;
    bit  hold_request;

    vector3_arithmetic_unit dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_kind,
        .i_ux, .i_uy, .i_uz, .i_vx, .i_vy, .i_vz, .i_factor,
        .o_valid, .i_ready, .o_rx, .o_ry, .o_rz, .o_scalar, .o_overflow, .o_zero_vector
    );

    vector3_arithmetic_unit_checker checker_inst (
        .i_clk, .i_rst_n,
        .i_in_valid(i_valid), .i_in_ready(o_ready), .i_kind,
        .i_ux, .i_uy, .i_uz, .i_vx, .i_vy, .i_vz, .i_factor,
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_rx(o_rx), .i_ry(o_ry), .i_rz(o_rz), .i_scalar(o_scalar),
        .i_overflow(o_overflow), .i_zero_vector(o_zero_vector),
        .o_fail_count(fail_count), .o_pending(outstanding), .o_checked(checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard limit on the run; a correct run ends far sooner than this.
    initial begin
        #4000000;
        $display("Timeout: the run did not finish in time");
        $display("Some tests failed");
        $finish;
    end

    // Present one operand word, after an optional random gap, and hold it until taken.
    task automatic send_word(input logic [2:0] kind, input logic [31:0] ux, input logic [31:0] uy,
                             input logic [31:0] uz, input logic [31:0] vx, input logic [31:0] vy,
                             input logic [31:0] vz, input logic [31:0] factor);
        int gap;
        gap = send_gaps ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_kind   <= kind;
        i_ux     <= ux;
        i_uy     <= uy;
        i_uz     <= uz;
        i_vx     <= vx;
        i_vy     <= vy;
        i_vz     <= vz;
        i_factor <= factor;
        // Values read just after the edge are still those the block saw at it.
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        words_sent++;
    endtask

    // Stop offering words and wait until every predicted result has come back.
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // A component drawn from a spread of magnitudes, so that rounding, saturation
    // and the normalise pre-shift all get exercised.
    function automatic logic [31:0] rand_component();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $signed($urandom()) >>> $urandom_range(1, 30);
            2: return $signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000;
            3: case ($urandom_range(0, 4))
                   0: return 32'h8000_0000;
                   1: return 32'h7fff_ffff;
                   2: return 32'h0001_0000;
                   3: return 32'hffff_0000;
                   default: return 32'h0;
               endcase
            4: return $urandom_range(0, 3);
            default: return $signed($urandom()) >>> 12;
        endcase
    endfunction

    task automatic send_random_word();
        logic [2:0] kind;
        logic [31:0] ux, uy, uz;
        kind = ($urandom_range(0, 40) == 0) ? OP_SPARE : 3'($urandom_range(0, 6));
        ux = rand_component();
        uy = rand_component();
        uz = rand_component();
        if (kind == v3au_pkg::OP_NORM && $urandom_range(0, 9) == 0) begin
            ux = '0;
            uy = '0;
            uz = '0;
        end
        send_word(kind, ux, uy, uz, rand_component(), rand_component(), rand_component(),
                  rand_component());
    endtask

    // Result side: random stalls per word, plus one long hold-off on request.
    initial begin
        int stall;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        i_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (o_valid || hold_request) begin
                stall = sink_stalls ? $urandom_range(0, 16) : 0;
                if (hold_request) begin
                    hold_request = 1'b0;
                    stall = LongHold;
                end
                if (stall > 0) begin
                    i_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                    i_ready <= 1'b1;
                end
            end
        end
    end

    initial begin
        words_sent    = 0;
        send_gaps     = 1'b0;
        sink_stalls   = 1'b0;
        hold_request  = 1'b0;
        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_kind   <= v3au_pkg::OP_ADD;
        i_ux     <= '0;
        i_uy     <= '0;
        i_uz     <= '0;
        i_vx     <= '0;
        i_vy     <= '0;
        i_vz     <= '0;
        i_factor <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words: field extremes, each operation, saturation in both
        // directions, a rounding tie, normalising a zero vector and the spare code.
        send_word(v3au_pkg::OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'h7fff_ffff,
                  32'h8000_0000, 32'hffff_ffff, 32'h0);
        send_word(v3au_pkg::OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1,
                  32'hffff_ffff, 32'h8000_0000, 32'h0);
        send_word(v3au_pkg::OP_SCALE, 32'h1, 32'hffff_ffff, 32'h0003_0000, 32'h0, 32'h0,
                  32'h0, 32'h0000_8000);
        send_word(v3au_pkg::OP_SCALE, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, 32'h0,
                  32'h0, 32'h0, 32'h8000_0000);
        send_word(v3au_pkg::OP_DOT, 32'h0002_0000, 32'h0003_0000, 32'hfffc_0000,
                  32'h0001_8000, 32'h0000_4000, 32'h0002_0000, 32'h0);
        send_word(v3au_pkg::OP_DOT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0);
        send_word(v3au_pkg::OP_CROSS, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000,
                  32'h0, 32'h0);
        send_word(v3au_pkg::OP_CROSS, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                  32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
        send_word(v3au_pkg::OP_LEN, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0, 32'h0,
                  32'h0, 32'h0);
        send_word(v3au_pkg::OP_LEN, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0,
                  32'h0, 32'h0, 32'h0);
        send_word(v3au_pkg::OP_NORM, 32'h0, 32'h0, 32'h0, 32'hffff_ffff, 32'hffff_ffff,
                  32'hffff_ffff, 32'hffff_ffff);
        send_word(v3au_pkg::OP_NORM, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(v3au_pkg::OP_NORM, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0,
                  32'h0, 32'h0, 32'h0);
        send_word(v3au_pkg::OP_NORM, 32'h0003_0000, 32'hfffc_0000, 32'h0, 32'h0, 32'h0,
                  32'h0, 32'h0);
        send_word(OP_SPARE, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);

        // Pause the source entirely until the pipeline has emptied.
        drain_pipeline();

        // Random words in phases: back-to-back, gaps only, stalls only, both,
        // and one long hold-off on the result side so the pipeline fills and blocks.
        for (int phase = 0; phase < 7; phase++) begin
            send_gaps   = phase[0];
            sink_stalls = phase[1];
            if (phase == 4) hold_request = 1'b1;
            repeat (100) send_random_word();
            if (phase == 5) drain_pipeline();
        end
        i_valid <= 1'b0;

        while (outstanding != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("Run covered %0d operand words over all seven operations and the spare code,",
                 words_sent);
        $display("with %0d result words checked under random gaps, stalls and a long hold-off.",
                 checked);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/v3au_pkg.sv
src/v3au_root.sv
src/v3au_div.sv
src/vector3_arithmetic_unit.sv
dv/vector3_arithmetic_unit_checker.sv
dv/vector3_arithmetic_unit_tb.sv
